/* rtl/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the round-robin thread scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

	// per-slot thread status
	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_RUNNING = 2'd1,
		ST_LOCKED  = 2'd2,
		ST_STOPPED = 2'd3
	} status_t;

	// request codes
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_LOCK   = 3'd1;
	localparam logic [2:0] REQ_UNLOCK = 3'd2;
	localparam logic [2:0] REQ_CREATE = 3'd3;
	localparam logic [2:0] REQ_STOP   = 3'd4;
	localparam logic [2:0] REQ_RESUME = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the incoming request word
		logic exec;   // apply the captured request and post the result
	} cmd_t;

endpackage

/* rtl/rrts_ctrl.sv */
// ----------------------------------------------------------------------------
// rrts_ctrl
// Request sequencer: takes a request word, then applies it in the EXEC state.
// ----------------------------------------------------------------------------
module rrts_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output rrts_pkg::cmd_t cmd
);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy    <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
						busy    <= 1'b1;
					end
				end
				EXEC: begin
					state_q <= IDLE;
					busy    <= 1'b0;
				end
				default: begin
					state_q <= IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end

	assign cmd.load = start && (state_q == IDLE);
	assign cmd.exec = (state_q == EXEC);

endmodule

/* rtl/rrts_datapath.sv */
// ----------------------------------------------------------------------------
// rrts_datapath
// Slot status table, slot count, current slot, round-robin pick and the
// registered result word.
// ----------------------------------------------------------------------------
module rrts_datapath #(
	parameter int MAX_THREADS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rrts_pkg::cmd_t cmd,
	input  logic [2:0]     req_type,
	input  logic [3:0]     thread_index,
	output logic           done,
	output logic           switched,
	output logic [3:0]     running_index,
	output logic [3:0]     previous_index,
	output logic           result_code
);

	localparam int IW   = $clog2(MAX_THREADS);
	localparam int CW   = $clog2(MAX_THREADS + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;

	rrts_pkg::status_t status_q [MAX_THREADS];
	rrts_pkg::status_t status_d [MAX_THREADS];
	logic [CW-1:0]     used_q, used_d;
	logic [IW-1:0]     cur_q, cur_d;
	logic [2:0]        req_q;
	logic [3:0]        idx_q;

	rrts_pkg::status_t cur_st;
	logic [MAX_THREADS-1:0] rdy, rdy_hi;
	logic [IW-1:0]     pick, pick_hi, pick_any;
	logic              got_hi, got_any;
	logic              target_ok, full;
	logic [IW-1:0]     tgt;
	logic              sw_d, rej_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			idx_q <= thread_index;
		end
	end

	assign cur_st = status_q[cur_q];
	assign full   = (used_q == CW'(MAX_THREADS));
	assign tgt    = IW'(idx_q);
	assign target_ok = (idx_q != 4'd0)
		&& (CMPW'(idx_q) != CMPW'(cur_q))
		&& (CMPW'(idx_q) < CMPW'(used_q));

	// ready slots in use, with a running current slot already demoted
	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++) begin
			rdy[i] = (CW'(i) < used_q) &&
				((status_q[i] == rrts_pkg::ST_READY) ||
				 ((IW'(i) == cur_q) && (cur_st == rrts_pkg::ST_RUNNING)));
			rdy_hi[i] = rdy[i] && (IW'(i) > cur_q);
		end
	end

	// lowest ready slot above current, else lowest ready slot overall
	always_comb begin
		pick_hi  = '0;
		pick_any = '0;
		got_hi   = 1'b0;
		got_any  = 1'b0;
		for (int i = MAX_THREADS - 1; i >= 0; i--) begin
			if (rdy_hi[i]) begin
				pick_hi = IW'(i);
				got_hi  = 1'b1;
			end
			if (rdy[i]) begin
				pick_any = IW'(i);
				got_any  = 1'b1;
			end
		end
		pick = got_hi ? pick_hi : pick_any;
	end

	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++) begin
			status_d[i] = status_q[i];
		end
		used_d = used_q;
		cur_d  = cur_q;
		sw_d   = 1'b0;
		rej_d  = 1'b0;
		case (req_q)
			rrts_pkg::REQ_TICK: begin
				if (cur_st != rrts_pkg::ST_LOCKED) begin
					if (cur_st == rrts_pkg::ST_RUNNING) begin
						status_d[cur_q] = rrts_pkg::ST_READY;
					end
					if (got_any) begin
						status_d[pick] = rrts_pkg::ST_RUNNING;
						cur_d          = pick;
						sw_d           = (pick != cur_q);
					end
				end
			end
			rrts_pkg::REQ_LOCK: begin
				status_d[cur_q] = rrts_pkg::ST_LOCKED;
			end
			rrts_pkg::REQ_UNLOCK: begin
				status_d[cur_q] = rrts_pkg::ST_RUNNING;
			end
			rrts_pkg::REQ_CREATE: begin
				if (full) begin
					rej_d = 1'b1;
				end else begin
					status_d[IW'(used_q)] = rrts_pkg::ST_READY;
					used_d = used_q + CW'(1);
				end
			end
			rrts_pkg::REQ_STOP: begin
				if (target_ok) status_d[tgt] = rrts_pkg::ST_STOPPED;
				else rej_d = 1'b1;
			end
			rrts_pkg::REQ_RESUME: begin
				if (target_ok) status_d[tgt] = rrts_pkg::ST_READY;
				else rej_d = 1'b1;
			end
			default: begin
				rej_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_THREADS; i++) begin
				status_q[i] <= (i == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_READY;
			end
			used_q <= CW'(1);
			cur_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.exec;
			if (cmd.exec) begin
				for (int i = 0; i < MAX_THREADS; i++) begin
					status_q[i] <= status_d[i];
				end
				used_q <= used_d;
				cur_q  <= cur_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			switched       <= sw_d;
			running_index  <= 4'(cur_d);
			previous_index <= 4'(cur_q);
			result_code    <= rej_d;
		end
	end

endmodule

/* rtl/round_robin_thread_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread slot table with round-robin scheduling, lock, unlock, create, stop, resume.
// ----------------------------------------------------------------------------
// usage:
//   a request word (req_type, thread_index) is taken on a rising edge with
//   start high and busy low. busy stays high for the one cycle in which the
//   request is applied to the slot table.
//   one result word per request appears on switched, running_index,
//   previous_index and result_code for exactly one cycle with done high.
//   the request word is captured at the accepting edge and applied while
//   busy is high; done and the result word are registered at the same edge.
//   no new request is taken while busy is high; the next request may be taken
//   in the cycle that done is high, since the result sits in its own
//   output registers. the round-robin pick over all slots settles within
//   the apply cycle.
//   reset (arst_n low): slot 0 running, other slots ready, one slot in use,
//   current slot 0, no result pending.
//   the receiver cannot stall; done is a strobe and must be taken when seen.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
	parameter int MAX_THREADS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] req_type,
	input  logic [3:0] thread_index,
	output logic       done,
	output logic       switched,
	output logic [3:0] running_index,
	output logic [3:0] previous_index,
	output logic       result_code
);

	rrts_pkg::cmd_t cmd;

	rrts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	rrts_datapath #(
		.MAX_THREADS (MAX_THREADS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.thread_index   (thread_index),
		.done           (done),
		.switched       (switched),
		.running_index  (running_index),
		.previous_index (previous_index),
		.result_code    (result_code)
	);

endmodule
